// File: sv/svi_pkg.sv
package svi_pkg;

  // Fraction bits of the sweep position, default for the top level
  localparam int FRACTION_BITS_DEF = 16;

  // Numerator width of the pulse scaling divide: span (16 b) times angle (8 b)
  localparam int PULSE_NUM_W = 24;

  localparam logic [7:0]  FULL_ANGLE  = 8'd180;
  localparam logic [7:0]  ANGLE_RESET = 8'd90;
  localparam logic [15:0] MIN_RESET   = 16'd500;
  localparam logic [15:0] MAX_RESET   = 16'd2500;
  localparam logic [15:0] PULSE_RESET = 16'd1500;
  // Added before the divide to round up when the pulse range is descending
  localparam logic [23:0] PULSE_ROUND = 24'd179;

  // Divide by 180 as (x / 4) / 45: ceil(2^28 / 45), exact for x / 4 below 2^22
  localparam logic [22:0] PULSE_RECIP       = 23'd5965233;
  localparam int          PULSE_RECIP_SHIFT = 28;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SET   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MIRROR = 2'd0,
    REG_TRIM   = 2'd1,
    REG_MIN    = 2'd2,
    REG_MAX    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAP,
    ST_DIV,
    ST_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  target_angle;
    logic [15:0] sweep_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic [7:0]  logical_angle;
    logic        move_done;
  } out_item_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic capture;
    logic decode;
    logic map;
    logic write;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic need_map;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/servo_sweep_interpolator.sv
// Servo sweep interpolator: one hobby servo channel.
//
// Input channel (in_valid / in_stall / in_data) carries one command per
// transaction: a one-millisecond tick, a start of a linear sweep, or a set of
// the angle at once. Every transaction yields exactly one result transaction
// on the output channel (out_valid / out_stall / out_data): pulse width in
// microseconds, logical angle and a move-done flag. The configuration
// channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no command is in flight.
//
// One transaction at a time; the next command can be taken in the same cycle
// that the previous result turns valid. A command with nothing to do (idle
// tick, empty start, unused code) goes straight to the result. A tick or set
// remaps the pulse (registered product, then reciprocal multiply for the
// divide by 180). A sweep start runs the restoring divider, one quotient bit
// a cycle, to plan the step.
// Reset (rst_n low, synchronous) puts the angle at 90 degrees with a 1500 us
// pulse and default mirror, trim and pulse limits. While the receiver stalls,
// hold the result in the output register; the next command is still taken
// and worked on, and its result waits until the held transaction is taken.
module servo_sweep_interpolator #(
  parameter int FRACTION_BITS = svi_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  svi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output svi_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  svi_pkg::dp_cmd_t  cmd;
  svi_pkg::dp_stat_t stat;

  // Registers take any write at once
  assign cfg_ready = 1'b1;

  svi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  svi_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sv/svi_div.sv
module svi_div #(
  parameter int NUM_W = svi_pkg::PULSE_NUM_W,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit a cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: sv/svi_dp.sv
module svi_dp #(
  parameter int FRACTION_BITS = svi_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  svi_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  svi_pkg::dp_cmd_t    cmd,
  output svi_pkg::dp_stat_t   stat,
  input  logic                out_stall,
  output logic                out_valid,
  output svi_pkg::out_item_t  out_data
);

  localparam int POS_W   = 8 + FRACTION_BITS;
  localparam int MAP_W   = svi_pkg::PULSE_NUM_W;
  localparam int RECIP_W = MAP_W - 2 + $bits(svi_pkg::PULSE_RECIP);

  // Captured transaction
  logic [1:0]  cmd_r;
  logic [7:0]  tgt_r;
  logic [15:0] dur_r;
  logic [7:0]  tgt_sat;

  // Configuration
  logic              mirror_r, mirror_nxt;
  logic signed [7:0] trim_r, trim_nxt;
  logic [15:0]       min_r, min_nxt;
  logic [15:0]       max_r, max_nxt;

  // Servo state
  logic [7:0]       angle_r, angle_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] step_r, step_nxt;
  logic [15:0]      taken_r, taken_nxt;
  logic [15:0]      planned_r, planned_nxt;
  logic [15:0]      pulse_r, pulse_nxt;
  logic             neg_r, neg_nxt;
  logic             desc_r, desc_nxt;

  logic                out_valid_r, out_valid_nxt;
  svi_pkg::out_item_t  out_r, out_nxt;

  // Pulse scaling pipeline
  logic [MAP_W-1:0]   map_num_r;
  logic               map_done_r;
  logic [15:0]        pulse_q_r;
  logic [MAP_W-3:0]   quarter;
  logic [RECIP_W-1:0] recip_prod;

  logic [7:0]        diff;
  logic              pending;
  logic              move_ok;
  logic [POS_W-1:0]  pos_sum;
  logic [7:0]        pos_int;
  logic [7:0]        tick_angle;
  logic signed [9:0] ang_s, trim_s, mapped_s;
  logic [7:0]        map_angle;
  logic              desc;
  logic [15:0]       span;
  logic [23:0]       prod;
  logic [23:0]       map_num;
  logic              div_go;
  logic [POS_W-1:0]  div_num;
  logic [15:0]       div_den;
  logic [POS_W-1:0]  div_quo;
  logic              div_done;
  logic [POS_W-1:0]  step_mag;

  assign tgt_sat = (in_data.target_angle > svi_pkg::FULL_ANGLE) ?
                   svi_pkg::FULL_ANGLE : in_data.target_angle;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_data.command;
      tgt_r <= tgt_sat;
      dur_r <= in_data.sweep_ms;
    end
  end

  assign pending = taken_r < planned_r;
  assign diff    = (tgt_r >= angle_r) ? tgt_r - angle_r : angle_r - tgt_r;
  assign move_ok = (diff != 8'd0) && (dur_r != 16'd0);

  assign pos_sum    = pos_r + step_r;
  assign pos_int    = pos_sum[POS_W-1 -: 8];
  assign tick_angle = (pos_int > svi_pkg::FULL_ANGLE) ? svi_pkg::FULL_ANGLE : pos_int;

  // Mirror, trim and clamp the logical angle
  assign ang_s    = signed'({2'b00, angle_r});
  assign trim_s   = signed'({{2{trim_r[7]}}, trim_r});
  assign mapped_s = mirror_r ? 10'sd180 - ang_s - trim_s : ang_s + trim_s;

  always_comb begin
    if (mapped_s < 10'sd0) begin
      map_angle = 8'd0;
    end else if (mapped_s > 10'sd180) begin
      map_angle = svi_pkg::FULL_ANGLE;
    end else begin
      map_angle = mapped_s[7:0];
    end
  end

  assign desc    = max_r < min_r;
  assign span    = desc ? min_r - max_r : max_r - min_r;
  assign prod    = 24'(span) * 24'(map_angle);
  assign map_num = desc ? prod + svi_pkg::PULSE_ROUND : prod;

  // Divide the registered product by 180: drop two bits, then reciprocal of 45
  assign quarter    = map_num_r[MAP_W-1:2];
  assign recip_prod = RECIP_W'(quarter) * RECIP_W'(svi_pkg::PULSE_RECIP);

  // The divider only plans sweeps: (diff << FRACTION_BITS) / duration
  assign div_go  = cmd.decode && stat.need_div;
  assign div_num = {diff, {FRACTION_BITS{1'b0}}};
  assign div_den = dur_r;

  svi_div #(
    .NUM_W (POS_W),
    .DEN_W (16)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign step_mag = div_quo;

  always_comb begin
    mirror_nxt    = mirror_r;
    trim_nxt      = trim_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    angle_nxt     = angle_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    taken_nxt     = taken_r;
    planned_nxt   = planned_r;
    pulse_nxt     = pulse_r;
    neg_nxt       = neg_r;
    desc_nxt      = desc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (cfg_we) begin
      unique case (svi_pkg::cfg_idx_t'(cfg_index))
        svi_pkg::REG_MIRROR: mirror_nxt = cfg_data[0];
        svi_pkg::REG_TRIM:   trim_nxt   = signed'(cfg_data[7:0]);
        svi_pkg::REG_MIN:    min_nxt    = cfg_data;
        svi_pkg::REG_MAX:    max_nxt    = cfg_data;
      endcase
    end

    if (cmd.decode) begin
      if (cmd_r == svi_pkg::CMD_TICK && pending) begin
        pos_nxt   = pos_sum;
        angle_nxt = tick_angle;
        taken_nxt = taken_r + 16'd1;
      end else if (cmd_r == svi_pkg::CMD_SET) begin
        angle_nxt = tgt_r;
      end else if (cmd_r == svi_pkg::CMD_START) begin
        taken_nxt = 16'd0;
        if (move_ok) begin
          pos_nxt     = {angle_r, {FRACTION_BITS{1'b0}}};
          planned_nxt = dur_r;
          neg_nxt     = tgt_r < angle_r;
        end else begin
          planned_nxt = 16'd0;
        end
      end
    end

    if (cmd.map) begin
      desc_nxt = desc;
    end

    if (cmd.write) begin
      if (cmd_r == svi_pkg::CMD_START) begin
        step_nxt = neg_r ? POS_W'(~step_mag + 1'b1) : step_mag;
      end else begin
        pulse_nxt = desc_r ? min_r - pulse_q_r : min_r + pulse_q_r;
      end
    end

    if (cmd.load_out) begin
      out_nxt.pulse_width   = pulse_r;
      out_nxt.logical_angle = angle_r;
      out_nxt.move_done     = taken_r >= planned_r;
      out_valid_nxt         = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    desc_r <= desc_nxt;
    out_r  <= out_nxt;
    if (cmd.map) begin
      map_num_r <= map_num;
    end
    if (map_done_r) begin
      pulse_q_r <= recip_prod[svi_pkg::PULSE_RECIP_SHIFT +: 16];
    end
    if (!rst_n) begin
      mirror_r    <= 1'b0;
      trim_r      <= 8'sd0;
      min_r       <= svi_pkg::MIN_RESET;
      max_r       <= svi_pkg::MAX_RESET;
      angle_r     <= svi_pkg::ANGLE_RESET;
      pos_r       <= '0;
      step_r      <= '0;
      taken_r     <= 16'd0;
      planned_r   <= 16'd0;
      pulse_r     <= svi_pkg::PULSE_RESET;
      out_valid_r <= 1'b0;
      map_done_r  <= 1'b0;
    end else begin
      mirror_r    <= mirror_nxt;
      trim_r      <= trim_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      angle_r     <= angle_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      taken_r     <= taken_nxt;
      planned_r   <= planned_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
      map_done_r  <= cmd.map;
    end
  end

  assign stat.need_div = (cmd_r == svi_pkg::CMD_START) && move_ok;
  assign stat.need_map = ((cmd_r == svi_pkg::CMD_TICK) && pending) ||
                         (cmd_r == svi_pkg::CMD_SET);
  assign stat.div_done = div_done || map_done_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/svi_ctrl.sv
module svi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  svi_pkg::dp_stat_t stat,
  output svi_pkg::dp_cmd_t  cmd
);

  svi_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = svi_pkg::ST_DECODE;
        end
      end
      svi_pkg::ST_DECODE: begin
        if (stat.need_div) begin
          state_nxt = svi_pkg::ST_DIV;
        end else if (stat.need_map) begin
          state_nxt = svi_pkg::ST_MAP;
        end else begin
          state_nxt = svi_pkg::ST_RESULT;
        end
      end
      svi_pkg::ST_MAP: begin
        state_nxt = svi_pkg::ST_DIV;
      end
      svi_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = svi_pkg::ST_WRITE;
        end
      end
      svi_pkg::ST_WRITE: begin
        state_nxt = svi_pkg::ST_RESULT;
      end
      svi_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          state_nxt = svi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      svi_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      svi_pkg::ST_DECODE: cmd.decode   = 1'b1;
      svi_pkg::ST_MAP:    cmd.map      = 1'b1;
      svi_pkg::ST_DIV:    cmd          = '0;
      svi_pkg::ST_WRITE:  cmd.write    = 1'b1;
      svi_pkg::ST_RESULT: cmd.load_out = stat.out_free;
      default:            cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/svi_checker.sv
module svi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input svi_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // One command at a time: stall straight after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in flight");

  // A fresh result only comes from a command in flight
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no command in flight");

  // Logical angle never leaves the servo range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.logical_angle <= svi_pkg::FULL_ANGLE)
    else $error("logical angle above full range");

endmodule

bind servo_sweep_interpolator svi_checker u_svi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC  = svi_pkg::FRACTION_BITS_DEF;
  localparam int POS_W = 8 + FRAC;

  // The command field is two bits wide; the top code has no enum member
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Directed stimulus: one command per row, with a literal expectation where
  // the answer is obvious (reset state, end stops, degenerate sweeps)
  typedef struct packed {
    svi_pkg::in_item_t  item;
    logic               has_want;
    svi_pkg::out_item_t want;
  } stim_row_t;

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // reset state: tick with no sweep, unused code
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b1, '{16'd1500, 8'd90,  1'b1}},
    '{'{CMD_UNUSED,         8'hFF,  16'hFFFF}, 1'b1, '{16'd1500, 8'd90,  1'b1}},
    // end stops and saturation of the target
    '{'{svi_pkg::CMD_SET,   8'd0,   16'hFFFF}, 1'b1, '{16'd500,  8'd0,   1'b1}},
    '{'{svi_pkg::CMD_SET,   8'd180, 16'h0000}, 1'b1, '{16'd2500, 8'd180, 1'b1}},
    '{'{svi_pkg::CMD_SET,   8'hFF,  16'h0000}, 1'b1, '{16'd2500, 8'd180, 1'b1}},
    // zero duration, then zero difference: no sweep
    '{'{svi_pkg::CMD_START, 8'd0,   16'h0000}, 1'b1, '{16'd2500, 8'd180, 1'b1}},
    '{'{svi_pkg::CMD_START, 8'd180, 16'h0005}, 1'b1, '{16'd2500, 8'd180, 1'b1}},
    // downward sweep, interrupted by a set, resumed from the sweep position
    '{'{svi_pkg::CMD_START, 8'd0,   16'h0004}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_SET,   8'd100, 16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    // longest sweep with a saturated target, ticks with junk fields
    '{'{svi_pkg::CMD_START, 8'hFF,  16'hFFFF}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'hFF,  16'hFFFF}, 1'b0, '0},
    // single-step sweep, then a fractional downward step
    '{'{svi_pkg::CMD_START, 8'd90,  16'h0001}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_START, 8'd7,   16'h0003}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{svi_pkg::CMD_TICK,  8'd0,   16'h0000}, 1'b0, '0},
    '{'{CMD_UNUSED,         8'd0,   16'h0000}, 1'b0, '0}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  svi_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  svi_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = svi_pkg::REG_MIRROR;
  logic [15:0]        cfg_data  = '0;

  // Predictor copy of the registers
  logic              cfg_mirror;
  logic signed [7:0] cfg_trim;
  logic [15:0]       cfg_min;
  logic [15:0]       cfg_max;

  // Predictor copy of the servo state
  logic [7:0]       sv_angle;
  logic [POS_W-1:0] sv_pos;
  logic [31:0]      sv_step;
  logic [15:0]      sv_taken;
  logic [15:0]      sv_planned;
  logic [15:0]      sv_pulse;

  svi_pkg::out_item_t pulse_readings_q [$];
  int                 mismatches = 0;
  int                 sent_count = 0;
  int                 burst_left = 0;
  int                 stall_left = 0;
  int                 stall_pct  = 0;

  servo_sweep_interpolator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Angle to pulse width: mirror (trim negated), trim, clamp, then scale.
  // A descending range rounds the subtracted part up, so the result floors.
  function automatic logic [15:0] map_pulse(logic [7:0] angle);
    int a;
    int lo;
    int hi;
    lo = cfg_min;
    hi = cfg_max;
    if (cfg_mirror) begin
      a = int'(svi_pkg::FULL_ANGLE) - int'(angle) - int'(cfg_trim);
    end else begin
      a = int'(angle) + int'(cfg_trim);
    end
    if (a < 0) a = 0;
    if (a > int'(svi_pkg::FULL_ANGLE)) a = int'(svi_pkg::FULL_ANGLE);
    if (hi >= lo) begin
      return 16'(lo + ((hi - lo) * a) / int'(svi_pkg::FULL_ANGLE));
    end
    return 16'(lo - ((lo - hi) * a + int'(svi_pkg::PULSE_ROUND)) /
               int'(svi_pkg::FULL_ANGLE));
  endfunction

  function automatic void write_angle(logic [7:0] angle);
    sv_angle = (angle > svi_pkg::FULL_ANGLE) ? svi_pkg::FULL_ANGLE : angle;
    sv_pulse = map_pulse(sv_angle);
  endfunction

  // Apply one command to the predicted servo and return the reading it gives
  function automatic svi_pkg::out_item_t advance_servo(svi_pkg::in_item_t it);
    logic [7:0]         tgt;
    logic [7:0]         diff;
    logic [31:0]        mag;
    svi_pkg::out_item_t res;
    tgt = (it.target_angle > svi_pkg::FULL_ANGLE) ? svi_pkg::FULL_ANGLE : it.target_angle;
    case (it.command)
      svi_pkg::CMD_TICK: begin
        if (sv_taken < sv_planned) begin
          // a negative step wraps through the position width
          sv_pos = sv_pos + sv_step[POS_W-1:0];
          write_angle(sv_pos[POS_W-1:FRAC]);
          sv_taken = sv_taken + 16'd1;
        end
      end
      svi_pkg::CMD_START: begin
        diff = (tgt >= sv_angle) ? tgt - sv_angle : sv_angle - tgt;
        if (diff == 8'd0 || it.sweep_ms == 16'd0) begin
          sv_taken   = '0;
          sv_planned = '0;
        end else begin
          mag        = (32'(diff) << FRAC) / 32'(it.sweep_ms);
          sv_step    = (tgt < sv_angle) ? -mag : mag;
          sv_pos     = {sv_angle, {FRAC{1'b0}}};
          sv_taken   = '0;
          sv_planned = it.sweep_ms;
        end
      end
      svi_pkg::CMD_SET: begin
        write_angle(tgt);
      end
      default: begin
      end
    endcase
    res.pulse_width   = sv_pulse;
    res.logical_angle = sv_angle;
    res.move_done     = (sv_taken >= sv_planned);
    return res;
  endfunction

  function automatic svi_pkg::in_item_t servo_cmd(logic [1:0] cmd, logic [7:0] tgt,
                                                  logic [15:0] dur);
    svi_pkg::in_item_t it;
    it.command      = cmd;
    it.target_angle = tgt;
    it.sweep_ms     = dur;
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Offer one command; the sender runs in bursts with random gaps between.
  // Predict at the accepting edge so expectations stay in transaction order.
  task automatic send_command(svi_pkg::in_item_t it, logic has_want,
                              svi_pkg::out_item_t want);
    int                 gap;
    svi_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted = advance_servo(it);
    pulse_readings_q.push_back(has_want ? want : predicted);
    sent_count++;
  endtask

  task automatic send_random(logic [1:0] cmd, logic [7:0] tgt);
    send_command(servo_cmd(cmd, tgt, 16'($urandom)), 1'b0, '0);
  endtask

  // Hold off the sender until every reading has come back
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (pulse_readings_q.size() != 0);
  endtask

  // Leave cfg_valid high across back-to-back writes; the caller drops it
  task automatic write_register(svi_pkg::cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      svi_pkg::REG_MIRROR: cfg_mirror = data[0];
      svi_pkg::REG_TRIM:   cfg_trim   = data[7:0];
      svi_pkg::REG_MIN:    cfg_min    = data;
      svi_pkg::REG_MAX:    cfg_max    = data;
      default:             ;
    endcase
  endtask

  // Receiver: stretches of random length, each with its own stall density,
  // including stretches that never stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(8, 160);
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 20;
        3:       stall_pct <= 50;
        default: stall_pct <= 80;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every accepted reading with the oldest expectation
  always @(posedge clk) begin : reading_check
    svi_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pulse_readings_q.size() == 0) begin
        report_mismatch("unrequested pulse_width", int'(out_data.pulse_width), 0);
      end else begin
        want = pulse_readings_q.pop_front();
        if (out_data.pulse_width !== want.pulse_width)
          report_mismatch("pulse_width", int'(out_data.pulse_width),
                          int'(want.pulse_width));
        if (out_data.logical_angle !== want.logical_angle)
          report_mismatch("logical_angle", int'(out_data.logical_angle),
                          int'(want.logical_angle));
        if (out_data.move_done !== want.move_done)
          report_mismatch("move_done", int'(out_data.move_done), int'(want.move_done));
      end
    end
  end

  initial begin : stimulus
    int          ph;
    int          k;
    int          nt;
    int          phase_end;
    int          choice;
    logic        set_mirror;
    logic [7:0]  set_trim;
    logic [15:0] set_min;
    logic [15:0] set_max;
    logic [7:0]  tgt;
    logic [15:0] dur;

    // Predictor starts from the reset state
    cfg_mirror = 1'b0;
    cfg_trim   = '0;
    cfg_min    = svi_pkg::MIN_RESET;
    cfg_max    = svi_pkg::MAX_RESET;
    sv_pos     = '0;
    sv_step    = '0;
    sv_taken   = '0;
    sv_planned = '0;
    write_angle(svi_pkg::ANGLE_RESET);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++) begin
      send_command(DIRECTED_ROWS[k].item, DIRECTED_ROWS[k].has_want, DIRECTED_ROWS[k].want);
    end

    // Random phases: end-stop register settings first, then random ones
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          set_mirror = 1'b1; set_trim = 8'h5A; set_min = 16'd0;     set_max = 16'hFFFF;
        end
        1: begin
          set_mirror = 1'b0; set_trim = 8'hA6; set_min = 16'hFFFF; set_max = 16'd0;
        end
        2: begin
          set_mirror = 1'b1; set_trim = 8'h80; set_min = 16'd1000;  set_max = 16'd2000;
        end
        3: begin
          set_mirror = 1'b0; set_trim = 8'h7F; set_min = 16'd2500;  set_max = 16'd500;
        end
        4: begin
          set_mirror = 1'b0; set_trim = 8'h00; set_min = 16'd1234;  set_max = 16'd1234;
        end
        default: begin
          set_mirror = 1'($urandom);
          set_trim   = 8'($urandom);
          set_min    = 16'($urandom);
          set_max    = 16'($urandom);
        end
      endcase

      // Reconfigure only with the block idle; upper data bits carry junk
      drain_readings();
      write_register(svi_pkg::REG_MIRROR, {15'($urandom), set_mirror});
      write_register(svi_pkg::REG_TRIM, {8'($urandom), set_trim});
      write_register(svi_pkg::REG_MIN, set_min);
      write_register(svi_pkg::REG_MAX, set_max);
      cfg_valid <= 1'b0;

      phase_end = sent_count + 80;
      while (sent_count < phase_end) begin
        choice = $urandom_range(0, 19);
        if (choice < 12) begin
          // Well-formed sweep: start, then ticks, now and then a set midway
          tgt = ($urandom_range(0, 9) == 0) ? sv_angle : 8'($urandom_range(0, 200));
          dur = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 30));
          send_command(servo_cmd(svi_pkg::CMD_START, tgt, dur), 1'b0, '0);
          nt = (dur > 16'd40) ? $urandom_range(1, 40) : int'(dur) + $urandom_range(0, 2);
          for (k = 0; k < nt; k++) begin
            if ($urandom_range(0, 11) == 0)
              send_random(svi_pkg::CMD_SET, 8'($urandom));
            else
              send_random(svi_pkg::CMD_TICK, 8'($urandom));
          end
        end else if (choice < 15) begin
          send_random(svi_pkg::CMD_SET, 8'($urandom));
        end else if (choice == 15) begin
          send_random(CMD_UNUSED, 8'($urandom));
        end else if (choice == 16) begin
          send_command(servo_cmd(svi_pkg::CMD_START, 8'($urandom), 16'd0), 1'b0, '0);
        end else if (choice == 17) begin
          drain_readings();
        end else begin
          send_random(svi_pkg::CMD_TICK, 8'($urandom));
        end
      end
    end

    // Let the last readings arrive, then watch a while for strays
    drain_readings();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
